[hdl/srsw_pkg.sv]
// ----------------------------------------------------------------------------
// srsw_pkg: shared types and constants for the selective-repeat send window
// Opcodes, status codes, register indexes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package srsw_pkg;

	localparam int OPCODE_W = 2;
	localparam int STATUS_W = 2;
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;
	localparam int REG_IX_W = 2;

	// register indexes (byte address / 4)
	localparam logic [REG_IX_W-1:0] REG_TOTAL   = 2'd0;
	localparam logic [REG_IX_W-1:0] REG_WINDOW  = 2'd1;
	localparam logic [REG_IX_W-1:0] REG_TIMEOUT = 2'd2;

	localparam int TIMEOUT_RESET = 3;

	typedef enum logic [OPCODE_W-1:0] {
		OP_SCHED = 2'd0,
		OP_ACK   = 2'd1,
		OP_TICK  = 2'd2
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_NACK  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_SCH_RD,
		S_SCH_EV,
		S_BASE_RD,
		S_BASE_EV,
		S_BASE_SET,
		S_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    load_in;
		logic    scan_init;
		logic    idx_inc;
		logic    clr_wr;
		logic    sch_wr;
		logic    ack_wr;
		logic    pend_load;
		logic    emit_pend;
		logic    emit_final;
		logic    status_set;
		status_t status_code;
		logic    base_load;
		logic    tick_inc;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		opcode_t op;
		logic    base_ok;
		logic    ack_oob;
		logic    ack_pos;
		logic    due;
		logic    pend;
		logic    idx_at_end;
		logic    rd_acked;
		logic    clr_last;
	} dp_stat_t;

endpackage

[hdl/srsw_cfg.sv]
// ----------------------------------------------------------------------------
// srsw_cfg: configuration registers
// APB-style register file for total packets, window length and timeout,
// plus the clamped values that the datapath works with.
// ----------------------------------------------------------------------------
module srsw_cfg #(
	parameter int MAX_PACKETS = 1024,
	parameter int WINDOW_MAX  = 8,
	parameter int STAMP_BITS  = 16,
	parameter int CNT_W       = 11,
	parameter int LEN_W       = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [srsw_pkg::APB_AW-1:0] paddr,
	input  logic [srsw_pkg::APB_DW-1:0] pwdata,
	output logic [srsw_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output logic [CNT_W-1:0]            eff_total,
	output logic [LEN_W-1:0]            eff_len,
	output logic [STAMP_BITS-1:0]       timeout
);
	import srsw_pkg::*;

	logic [CNT_W-1:0]      total_q;
	logic [LEN_W-1:0]      wlen_q;
	logic [STAMP_BITS-1:0] timeout_q;
	logic [REG_IX_W-1:0]   reg_ix;
	logic                  wr_beat;

	assign pready  = 1'b1;
	assign reg_ix  = paddr[APB_AW-1:2];
	assign wr_beat = psel && penable && pwrite;

	// write on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= CNT_W'(MAX_PACKETS);
			wlen_q    <= LEN_W'(WINDOW_MAX);
			timeout_q <= STAMP_BITS'(TIMEOUT_RESET);
		end else if (wr_beat) begin
			if (reg_ix == REG_TOTAL)   total_q   <= pwdata[CNT_W-1:0];
			if (reg_ix == REG_WINDOW)  wlen_q    <= pwdata[LEN_W-1:0];
			if (reg_ix == REG_TIMEOUT) timeout_q <= pwdata[STAMP_BITS-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (reg_ix == REG_TOTAL)        prdata = APB_DW'(total_q);
		else if (reg_ix == REG_WINDOW)  prdata = APB_DW'(wlen_q);
		else if (reg_ix == REG_TIMEOUT) prdata = APB_DW'(timeout_q);
	end

	// clamp zero to one and large values to the maximum
	always_comb begin
		if (total_q == '0)                        eff_total = CNT_W'(1);
		else if (total_q > CNT_W'(MAX_PACKETS))   eff_total = CNT_W'(MAX_PACKETS);
		else                                      eff_total = total_q;
		if (wlen_q == '0)                         eff_len = LEN_W'(1);
		else if (wlen_q > LEN_W'(WINDOW_MAX))     eff_len = LEN_W'(WINDOW_MAX);
		else                                      eff_len = wlen_q;
	end

	assign timeout = timeout_q;

endmodule

[hdl/srsw_dpath.sv]
// ----------------------------------------------------------------------------
// srsw_dpath: window datapath
// Packet tables (acked bit, sent bit and send stamp), window base, tick
// clock, scan index and the result register.
// ----------------------------------------------------------------------------
module srsw_dpath #(
	parameter int MAX_PACKETS = 1024,
	parameter int STAMP_BITS  = 16,
	parameter int IDX_W       = 10,
	parameter int CNT_W       = 11,
	parameter int LEN_W       = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  srsw_pkg::dp_cmd_t             cmd,
	output srsw_pkg::dp_stat_t            stat,
	input  logic [CNT_W-1:0]              eff_total,
	input  logic [LEN_W-1:0]              eff_len,
	input  logic [STAMP_BITS-1:0]         timeout,
	input  logic [srsw_pkg::OPCODE_W-1:0] opcode,
	input  logic [IDX_W-1:0]              ack_index,
	input  logic                          ack_positive,
	output logic                          result_valid,
	output logic                          send_valid,
	output logic [IDX_W-1:0]              send_index,
	output logic [CNT_W-1:0]              base_index,
	output logic                          all_done,
	output logic [srsw_pkg::STATUS_W-1:0] status,
	output logic                          last_of_run
);
	import srsw_pkg::*;

	localparam int SUM_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

	// packet tables
	logic                  acked_mem [MAX_PACKETS];
	logic [STAMP_BITS:0]   slot_mem  [MAX_PACKETS];

	opcode_t               op_q;
	logic [IDX_W-1:0]      ack_idx_q;
	logic                  ack_pos_q;
	logic [CNT_W-1:0]      base_q;
	logic [STAMP_BITS-1:0] tick_q;
	logic                  done_q;
	status_t               status_q;
	logic [CNT_W-1:0]      idx_q;
	logic [CNT_W-1:0]      end_q;
	logic                  pend_q;
	logic [IDX_W-1:0]      pend_idx_q;
	logic                  rd_acked_q;
	logic                  rd_sent_q;
	logic [STAMP_BITS-1:0] rd_stamp_q;

	logic                  res_valid_q;
	logic                  res_send_q;
	logic [IDX_W-1:0]      res_idx_q;
	logic [CNT_W-1:0]      res_base_q;
	logic                  res_done_q;
	status_t               res_status_q;
	logic                  res_last_q;

	logic [IDX_W-1:0]      idx_a;
	logic [CNT_W-1:0]      tm1;
	logic [SUM_W-1:0]      win_sum;
	logic [CNT_W-1:0]      win_end;
	logic [STAMP_BITS-1:0] elapsed;

	assign idx_a = idx_q[IDX_W-1:0];
	assign tm1   = eff_total - CNT_W'(1);

	// last index of the window, cut at the final packet
	always_comb begin
		win_sum = SUM_W'(base_q) + SUM_W'(eff_len) - SUM_W'(1);
		if (win_sum > SUM_W'(tm1)) win_end = tm1;
		else                       win_end = win_sum[CNT_W-1:0];
	end

	assign elapsed = tick_q - rd_stamp_q;

	// status toward the controller
	always_comb begin
		stat.op         = op_q;
		stat.base_ok    = base_q < eff_total;
		stat.ack_oob    = CNT_W'(ack_idx_q) >= eff_total;
		stat.ack_pos    = ack_pos_q;
		stat.due        = !rd_acked_q && (!rd_sent_q || (elapsed >= timeout));
		stat.pend       = pend_q;
		stat.idx_at_end = idx_q == end_q;
		stat.rd_acked   = rd_acked_q;
		stat.clr_last   = idx_q == CNT_W'(MAX_PACKETS - 1);
	end

	// capture the input item
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q      <= opcode_t'(opcode);
			ack_idx_q <= ack_index;
			ack_pos_q <= ack_positive;
		end
	end

	// window state, scan index and pending send
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			tick_q   <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			idx_q    <= '0;
			end_q    <= '0;
			pend_q   <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				status_q <= ST_OK;
				pend_q   <= 1'b0;
			end
			if (cmd.status_set) status_q <= cmd.status_code;
			if (cmd.tick_inc)   tick_q   <= tick_q + STAMP_BITS'(1);
			if (cmd.ack_wr && (CNT_W'(ack_idx_q) == tm1)) done_q <= 1'b1;
			if (cmd.scan_init) begin
				idx_q <= base_q;
				end_q <= win_end;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.pend_load) pend_q <= 1'b1;
			if (cmd.base_load) base_q <= idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pend_load) pend_idx_q <= idx_a;
	end

	// table writes: clearing sweep, send stamp, ack mark
	always_ff @(posedge clk) begin
		if (cmd.clr_wr)      slot_mem[idx_a] <= '0;
		else if (cmd.sch_wr) slot_mem[idx_a] <= {1'b1, tick_q};
		if (cmd.clr_wr)      acked_mem[idx_a]     <= 1'b0;
		else if (cmd.ack_wr) acked_mem[ack_idx_q] <= 1'b1;
	end

	// registered table read at the scan index
	always_ff @(posedge clk) begin
		rd_acked_q <= acked_mem[idx_a];
		{rd_sent_q, rd_stamp_q} <= slot_mem[idx_a];
	end

	// result register: one beat per emit command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else         res_valid_q <= cmd.emit_pend || cmd.emit_final;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_pend || cmd.emit_final) begin
			res_base_q <= base_q;
			res_done_q <= done_q;
			if (cmd.emit_pend) begin
				res_send_q   <= 1'b1;
				res_idx_q    <= pend_idx_q;
				res_status_q <= ST_OK;
				res_last_q   <= 1'b0;
			end else begin
				res_send_q   <= pend_q;
				res_idx_q    <= pend_q ? pend_idx_q : '0;
				res_status_q <= pend_q ? ST_OK : status_q;
				res_last_q   <= 1'b1;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign send_valid   = res_send_q;
	assign send_index   = res_idx_q;
	assign base_index   = res_base_q;
	assign all_done     = res_done_q;
	assign status       = res_status_q;
	assign last_of_run  = res_last_q;

endmodule

[hdl/srsw_ctrl.sv]
// ----------------------------------------------------------------------------
// srsw_ctrl: sequencer
// Runs the clearing sweep after reset, decodes each item and steps the
// datapath through the window scans one entry at a time.
// ----------------------------------------------------------------------------
module srsw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output srsw_pkg::dp_cmd_t  cmd,
	input  srsw_pkg::dp_stat_t stat
);
	import srsw_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else         state_q <= state_d;
	end

	assign busy = state_q != S_IDLE;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) state_d = S_IDLE;
				else               cmd.idx_inc = 1'b1;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.op)
					OP_SCHED: begin
						if (stat.base_ok) begin
							cmd.scan_init = 1'b1;
							state_d       = S_SCH_RD;
						end else begin
							state_d = S_FINISH;
						end
					end
					OP_ACK: begin
						if (stat.ack_oob) begin
							cmd.status_set  = 1'b1;
							cmd.status_code = ST_RANGE;
							state_d         = S_FINISH;
						end else begin
							if (stat.ack_pos) begin
								cmd.ack_wr = 1'b1;
							end else begin
								cmd.status_set  = 1'b1;
								cmd.status_code = ST_NACK;
							end
							if (stat.base_ok) begin
								cmd.scan_init = 1'b1;
								state_d       = S_BASE_RD;
							end else begin
								state_d = S_FINISH;
							end
						end
					end
					OP_TICK: begin
						cmd.tick_inc = 1'b1;
						state_d      = S_FINISH;
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_SCH_RD: state_d = S_SCH_EV;
			S_SCH_EV: begin
				// stamp a due packet and hold it back until the next one shows up
				if (stat.due) begin
					cmd.sch_wr    = 1'b1;
					cmd.pend_load = 1'b1;
					cmd.emit_pend = stat.pend;
				end
				if (stat.idx_at_end) begin
					state_d = S_FINISH;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SCH_RD;
				end
			end
			S_BASE_RD: state_d = S_BASE_EV;
			S_BASE_EV: begin
				// advance over acked packets up to one past the window end
				if (stat.rd_acked) begin
					cmd.idx_inc = 1'b1;
					state_d     = stat.idx_at_end ? S_BASE_SET : S_BASE_RD;
				end else begin
					state_d = S_BASE_SET;
				end
			end
			S_BASE_SET: begin
				cmd.base_load = 1'b1;
				state_d       = S_FINISH;
			end
			S_FINISH: begin
				cmd.emit_final = 1'b1;
				state_d        = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[hdl/selective_repeat_send_window_core.sv]
// ----------------------------------------------------------------------------
// selective_repeat_send_window_core: sender side of a selective-repeat window
// Start an item with start while busy is low. A schedule item returns one
// beat per packet to send (or one empty beat); every other item returns one
// beat. Beats are marked by result_valid for one cycle each and cannot be
// stalled; last_of_run flags the final beat of an item. A schedule walks the
// current window (cut at the final packet) and an ack walks the acked packets
// from the window base, through the single-port packet tables, reading each
// entry in a read state and judging it in an evaluate state. A tick, an
// out-of-range ack, an item whose window base is past the final packet and any
// other item skip the scan. After reset the tables are swept clear, one entry
// a cycle over all MAX_PACKETS entries, with busy high; register writes are taken meanwhile.
// ----------------------------------------------------------------------------
module selective_repeat_send_window_core #(
	parameter  int MAX_PACKETS = 1024,
	parameter  int WINDOW_MAX  = 8,
	parameter  int STAMP_BITS  = 16,
	localparam int IDX_W       = $clog2(MAX_PACKETS),
	localparam int CNT_W       = $clog2(MAX_PACKETS + 1),
	localparam int LEN_W       = $clog2(WINDOW_MAX + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [srsw_pkg::OPCODE_W-1:0] opcode,
	input  logic [IDX_W-1:0]              ack_index,
	input  logic                          ack_positive,
	output logic                          result_valid,
	output logic                          send_valid,
	output logic [IDX_W-1:0]              send_index,
	output logic [CNT_W-1:0]              base_index,
	output logic                          all_done,
	output logic [srsw_pkg::STATUS_W-1:0] status,
	output logic                          last_of_run,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [srsw_pkg::APB_AW-1:0]   paddr,
	input  logic [srsw_pkg::APB_DW-1:0]   pwdata,
	output logic [srsw_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import srsw_pkg::*;

	dp_cmd_t               cmd;
	dp_stat_t              stat;
	logic [CNT_W-1:0]      eff_total;
	logic [LEN_W-1:0]      eff_len;
	logic [STAMP_BITS-1:0] timeout;

	srsw_cfg #(
		.MAX_PACKETS (MAX_PACKETS),
		.WINDOW_MAX  (WINDOW_MAX),
		.STAMP_BITS  (STAMP_BITS),
		.CNT_W       (CNT_W),
		.LEN_W       (LEN_W)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.eff_total (eff_total),
		.eff_len   (eff_len),
		.timeout   (timeout)
	);

	srsw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	srsw_dpath #(
		.MAX_PACKETS (MAX_PACKETS),
		.STAMP_BITS  (STAMP_BITS),
		.IDX_W       (IDX_W),
		.CNT_W       (CNT_W),
		.LEN_W       (LEN_W)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.eff_total    (eff_total),
		.eff_len      (eff_len),
		.timeout      (timeout),
		.opcode       (opcode),
		.ack_index    (ack_index),
		.ack_positive (ack_positive),
		.result_valid (result_valid),
		.send_valid   (send_valid),
		.send_index   (send_index),
		.base_index   (base_index),
		.all_done     (all_done),
		.status       (status),
		.last_of_run  (last_of_run)
	);

	// no beat in the cycle after an item is taken
	a_no_beat_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !result_valid)
		else $error("result beat right after item accept");

	// an empty beat always closes its item
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !send_valid) |-> last_of_run)
		else $error("empty result beat not marked last");

	// beats before the last one are send requests
	a_inner_beats_send: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last_of_run) |-> send_valid)
		else $error("non-final beat without send request");

	// an ack error never comes with a send request
	a_err_no_send: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (status != ST_OK)) |-> !send_valid)
		else $error("send request with error status");

endmodule
